// File: design/cst_pkg.sv
`default_nettype none

package cst_pkg;

	// Token kinds as given on the kind port.
	localparam logic [4:0] K_IDENT      = 5'd0;
	localparam logic [4:0] K_TYPE       = 5'd1;
	localparam logic [4:0] K_CONST      = 5'd2;
	localparam logic [4:0] K_RETURN     = 5'd3;
	localparam logic [4:0] K_INT_LIT    = 5'd4;
	localparam logic [4:0] K_STRING     = 5'd5;
	localparam logic [4:0] K_LPAREN     = 5'd6;
	localparam logic [4:0] K_RPAREN     = 5'd7;
	localparam logic [4:0] K_LBRACE     = 5'd8;
	localparam logic [4:0] K_RBRACE     = 5'd9;
	localparam logic [4:0] K_SEMI       = 5'd10;
	localparam logic [4:0] K_ASSIGN     = 5'd11;
	localparam logic [4:0] K_COMMA      = 5'd12;
	localparam logic [4:0] K_BAD_NUM    = 5'd13;
	localparam logic [4:0] K_UNKNOWN    = 5'd14;
	localparam logic [4:0] K_UNTERM     = 5'd15;
	localparam logic [4:0] K_END        = 5'd16;

	// Characters with a meaning of their own.
	localparam logic [7:0] C_NUL    = 8'h00;
	localparam logic [7:0] C_TAB    = 8'h09;
	localparam logic [7:0] C_LF     = 8'h0A;
	localparam logic [7:0] C_SPACE  = 8'h20;
	localparam logic [7:0] C_QUOTE  = 8'h22;
	localparam logic [7:0] C_LPAREN = 8'h28;
	localparam logic [7:0] C_RPAREN = 8'h29;
	localparam logic [7:0] C_STAR   = 8'h2A;
	localparam logic [7:0] C_COMMA  = 8'h2C;
	localparam logic [7:0] C_DOT    = 8'h2E;
	localparam logic [7:0] C_SLASH  = 8'h2F;
	localparam logic [7:0] C_SEMI   = 8'h3B;
	localparam logic [7:0] C_EQUAL  = 8'h3D;
	localparam logic [7:0] C_LBRACE = 8'h7B;
	localparam logic [7:0] C_RBRACE = 8'h7D;

	// Keywords in match priority order: return, int, char*, const.
	localparam int KW_COUNT = 4;
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{"return", "int", "char*", "const"};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd3, 3'd5, 3'd5};
	localparam logic [4:0] KW_KIND [KW_COUNT] = '{K_RETURN, K_TYPE, K_TYPE, K_CONST};

	// Depth of the result queue.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	// Lexing modes, one-hot.
	typedef enum logic [5:0] {
		M_IDLE    = 6'b000001,
		M_SLASH   = 6'b000010,
		M_COMMENT = 6'b000100,
		M_IDENT   = 6'b001000,
		M_NUMBER  = 6'b010000,
		M_STRING  = 6'b100000
	} lex_mode_t;

	// One token as queued for the output channel.
	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [11:0] length;
		logic        last;
	} token_t;

	// Byte idx of keyword k; only called with idx below the keyword length.
	function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
		int sh;
		sh = 8 * (int'(KW_LEN[k]) - 1 - int'(idx));
		if (sh < 0) begin
			return C_NUL;
		end
		return KW_TEXT[k][sh +: 8];
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == C_SPACE || c == C_LF || c == C_TAB;
	endfunction

endpackage

`default_nettype wire

// File: design/c_subset_tokenizer.sv
// Tokenizer for a small C subset, one source byte per transfer.
// Input channel: ch_valid, ch_stall, ch. A byte of zero marks the end of
// the text; lexing then starts afresh while positions keep counting.
// Output channel: tok_valid, tok_stall, kind, start_res, length, last.
// Each byte gives zero, one or two tokens; last marks the final token
// that a byte causes.
// Throughput is one byte per cycle while the input is not stalled. A
// byte is lexed in the cycle it is transferred and its tokens enter a
// four-entry result queue; with the queue empty, the first token is
// offered in the next cycle. Two tokens from one byte leave in order.
// The input is stalled whenever the queue has fewer than two free
// entries, so a stall on the output side reaches the input once the
// queue holds more than two tokens; no token is ever dropped or repeated.
// Reset clears the queue and returns the lexer to idle at position zero.
`default_nettype none

module c_subset_tokenizer
	import cst_pkg::*;
#(
	parameter int POSITION_BITS = 16,
	parameter int LENGTH_MAX = 4095
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        ch_valid,
	output logic             ch_stall,
	input  wire logic [7:0]  ch,
	output logic             tok_valid,
	input  wire logic        tok_stall,
	output logic [4:0]       kind,
	output logic [15:0]      start_res,
	output logic [11:0]      length,
	output logic             last
);

	localparam int LB = $clog2(LENGTH_MAX + 1);
	localparam int SW = (POSITION_BITS < 16) ? POSITION_BITS : 16;
	localparam int LW = (LB < 12) ? LB : 12;
	localparam logic [LB-1:0] LEN_MAX = LB'(LENGTH_MAX);

	// Lexer state.
	lex_mode_t                mode_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] tok_start_q;
	logic [LB-1:0]            tok_len_q;
	logic [KW_COUNT-1:0]      cand_q;
	logic                     dot_q;

	// Result queue.
	token_t                   queue_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0]    wr_ptr_q;
	logic [Q_PTR_BITS-1:0]    rd_ptr_q;
	logic [Q_CNT_BITS-1:0]    count_q;

	// Next state and results of the current byte.
	lex_mode_t                mode_d;
	logic [POSITION_BITS-1:0] tok_start_d;
	logic [LB-1:0]            tok_len_d;
	logic [KW_COUNT-1:0]      cand_d;
	logic                     dot_d;
	logic                     do_idle;
	logic                     res_a_v;
	logic                     res_b_v;
	token_t                   res_a;
	token_t                   res_b;
	logic [LB-1:0]            len_grown;
	logic [KW_COUNT-1:0]      cand_match;
	logic [KW_COUNT-1:0]      cand_first;
	logic [4:0]               ident_kind;
	logic [15:0]              pos_out;
	logic [15:0]              start_out;
	logic [11:0]              len_out;
	logic [11:0]              grown_out;
	logic                     ch_xfer;
	logic                     tok_xfer;

	assign ch_xfer  = ch_valid && !ch_stall;
	assign tok_xfer = tok_valid && !tok_stall;

	// Saturating length step and the output views of position and length.
	assign len_grown = (tok_len_q < LEN_MAX) ? tok_len_q + 1'b1 : tok_len_q;
	assign pos_out   = 16'(pos_q[SW-1:0]);
	assign start_out = 16'(tok_start_q[SW-1:0]);
	assign len_out   = 12'(tok_len_q[LW-1:0]);
	assign grown_out = 12'(len_grown[LW-1:0]);

	// Keyword candidates that survive the current byte, and the first
	// candidate of exactly the open length.
	always_comb begin
		for (int k = 0; k < KW_COUNT; k++) begin
			cand_match[k] = (tok_len_q < LB'(KW_LEN[k])) && (kw_char(k, tok_len_q[2:0]) == ch);
			cand_first[k] = cand_q[k] && (tok_len_q == LB'(KW_LEN[k]));
		end
	end

	always_comb begin
		ident_kind = K_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (cand_first[k]) begin
				ident_kind = KW_KIND[k];
			end
		end
	end

	// Mode machine: the first result closes an open token, the second
	// comes from handling the byte as in idle mode.
	always_comb begin
		mode_d      = mode_q;
		tok_start_d = tok_start_q;
		tok_len_d   = tok_len_q;
		cand_d      = cand_q;
		dot_d       = dot_q;
		do_idle     = 1'b0;
		res_a_v     = 1'b0;
		res_a       = '{kind: K_IDENT, start: start_out, length: len_out, last: 1'b0};
		res_b_v     = 1'b0;
		res_b       = '{kind: K_END, start: pos_out, length: 12'd0, last: 1'b1};

		unique case (mode_q)
			M_SLASH: begin
				if (ch == C_SLASH) begin
					mode_d = M_COMMENT;
				end else begin
					do_idle = 1'b1;
				end
			end
			M_COMMENT: begin
				if (ch == C_LF) begin
					mode_d = M_IDLE;
				end else if (ch == C_NUL) begin
					do_idle = 1'b1;
				end
			end
			M_IDENT: begin
				if (is_alpha(ch) || is_digit(ch) || ch == C_STAR) begin
					cand_d    = cand_q & cand_match;
					tok_len_d = len_grown;
				end else begin
					res_a_v    = 1'b1;
					res_a.kind = ident_kind;
					do_idle    = 1'b1;
				end
			end
			M_NUMBER: begin
				if (is_digit(ch) || ch == C_DOT) begin
					tok_len_d = len_grown;
					dot_d     = dot_q || (ch == C_DOT);
				end else begin
					res_a_v    = 1'b1;
					res_a.kind = dot_q ? K_BAD_NUM : K_INT_LIT;
					do_idle    = 1'b1;
				end
			end
			M_STRING: begin
				if (ch == C_QUOTE) begin
					res_a_v      = 1'b1;
					res_a.kind   = K_STRING;
					res_a.length = grown_out;
					mode_d       = M_IDLE;
				end else if (ch == C_NUL) begin
					res_a_v    = 1'b1;
					res_a.kind = K_UNTERM;
					do_idle    = 1'b1;
				end else begin
					tok_len_d = len_grown;
				end
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase

		// Handling of a byte that starts afresh.
		if (do_idle) begin
			mode_d = M_IDLE;
			if (ch == C_NUL) begin
				res_b_v = 1'b1;
			end else if (is_space(ch)) begin
				mode_d = M_IDLE;
			end else if (ch == C_SLASH) begin
				mode_d = M_SLASH;
			end else if (is_alpha(ch) || is_digit(ch) || ch == C_DOT || ch == C_QUOTE) begin
				tok_start_d = pos_q;
				tok_len_d   = LB'(1);
				cand_d      = '1;
				dot_d       = 1'b0;
				if (is_alpha(ch)) begin
					mode_d = M_IDENT;
					for (int k = 0; k < KW_COUNT; k++) begin
						cand_d[k] = (kw_char(k, 3'd0) == ch);
					end
				end else if (ch == C_QUOTE) begin
					mode_d = M_STRING;
				end else begin
					mode_d = M_NUMBER;
					dot_d  = (ch == C_DOT);
				end
			end else begin
				res_b_v      = 1'b1;
				res_b.length = 12'd1;
				case (ch)
					C_LPAREN: res_b.kind = K_LPAREN;
					C_RPAREN: res_b.kind = K_RPAREN;
					C_LBRACE: res_b.kind = K_LBRACE;
					C_RBRACE: res_b.kind = K_RBRACE;
					C_SEMI:   res_b.kind = K_SEMI;
					C_EQUAL:  res_b.kind = K_ASSIGN;
					C_COMMA:  res_b.kind = K_COMMA;
					default:  res_b.kind = K_UNKNOWN;
				endcase
			end
		end

		// Back in idle the open token is cleared, its start kept.
		if (mode_d == M_IDLE) begin
			tok_len_d = '0;
			cand_d    = '1;
			dot_d     = 1'b0;
		end

		// The first result is final when no second one follows.
		res_a.last = !res_b_v;
	end

	// Lexer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			pos_q       <= '0;
			tok_start_q <= '0;
			tok_len_q   <= '0;
			cand_q      <= '1;
			dot_q       <= 1'b0;
		end else if (ch_xfer) begin
			mode_q      <= mode_d;
			pos_q       <= pos_q + 1'b1;
			tok_start_q <= tok_start_d;
			tok_len_q   <= tok_len_d;
			cand_q      <= cand_d;
			dot_q       <= dot_d;
		end
	end

	// Queue storage: up to two tokens are written per transfer.
	always_ff @(posedge clk) begin
		if (ch_xfer) begin
			if (res_a_v) begin
				queue_q[wr_ptr_q] <= res_a;
				if (res_b_v) begin
					queue_q[wr_ptr_q + 1'b1] <= res_b;
				end
			end else if (res_b_v) begin
				queue_q[wr_ptr_q] <= res_b;
			end
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + (ch_xfer ? Q_PTR_BITS'(res_a_v) + Q_PTR_BITS'(res_b_v)
				: Q_PTR_BITS'(0));
			rd_ptr_q <= rd_ptr_q + Q_PTR_BITS'(tok_xfer);
			count_q  <= count_q + (ch_xfer ? Q_CNT_BITS'(res_a_v) + Q_CNT_BITS'(res_b_v)
				: Q_CNT_BITS'(0)) - Q_CNT_BITS'(tok_xfer);
		end
	end

	// Stall the input unless two tokens fit.
	assign ch_stall  = count_q > Q_CNT_BITS'(Q_DEPTH - 2);
	assign tok_valid = count_q != '0;
	assign kind      = queue_q[rd_ptr_q].kind;
	assign start_res = queue_q[rd_ptr_q].start;
	assign length    = queue_q[rd_ptr_q].length;
	assign last      = queue_q[rd_ptr_q].last;

	// The queue never holds more tokens than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_BITS'(Q_DEPTH))
		else $error("result queue overflow");

	// In idle mode no token is open.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_IDLE) |-> (tok_len_q == '0 && cand_q == '1 && !dot_q))
		else $error("open token state left over in idle mode");

	// An end-of-text token is always the final one of its byte and empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && kind == K_END) |-> (last && length == 12'd0))
		else $error("end token not final or not empty");

	// A transfer that yields two tokens keeps the input stalled next cycle
	// unless the queue was empty or a token left in that cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ch_xfer && res_a_v && res_b_v && count_q >= Q_CNT_BITS'(1) && !tok_xfer) |=> ch_stall)
		else $error("queue accepted input without room for two tokens");

endmodule

`default_nettype wire
